FILE: hdl/fcnf_pkg.sv
// Shared constants, widths and the reciprocal table for the cascade noise figure block.
package fcnf_pkg;

	// Field widths of the stage and result items
	localparam int NF_W   = 16;
	localparam int GAIN_W = 24;
	localparam int X_W    = 25;

	// Shared multiplier operand and product widths
	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 32;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// log2(10)/10 in Q30, ln2 in Q30, 10*log10(2) in Q20
	localparam logic [28:0] K_LOG2_10_DIV10 = 29'd356689313;
	localparam logic [29:0] K_LN2           = 30'd744261118;
	localparam logic [21:0] K_DB_PER_LOG2   = 22'd3156528;
	localparam logic [30:0] Q30_ONE         = 31'd1073741824;

	// Taylor series length, log2 fraction bits, reciprocal scale
	localparam logic [3:0] SERIES_TERMS = 4'd13;
	localparam logic [4:0] SQUARE_LAST  = 5'd29;
	localparam int         RECIP_SHIFT  = 31;

	// Stage item
	typedef struct packed {
		logic signed [NF_W-1:0]   stage_nf;
		logic signed [NF_W-1:0]   stage_gain;
		logic                     last_stage;
	} stage_t;

	// ceil(2^31 / n): (a * r) >> 31 equals floor(a / n) for every series term, n from 2 to 13
	function automatic logic [30:0] recip_of(input logic [3:0] n);
		logic [30:0] r;
		unique case (n)
			4'd2:    r = 31'd1073741824;
			4'd3:    r = 31'd715827883;
			4'd4:    r = 31'd536870912;
			4'd5:    r = 31'd429496730;
			4'd6:    r = 31'd357913942;
			4'd7:    r = 31'd306783379;
			4'd8:    r = 31'd268435456;
			4'd9:    r = 31'd238609295;
			4'd10:   r = 31'd214748365;
			4'd11:   r = 31'd195225787;
			4'd12:   r = 31'd178956971;
			4'd13:   r = 31'd165191050;
			default: r = 31'd0;
		endcase
		return r;
	endfunction

endpackage

FILE: hdl/fcnf_if.sv
// Valid/ready channels for stage items in and cascade results out.
interface fcnf_stage_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] stage_nf;
	logic signed [15:0] stage_gain;
	logic               last_stage;

	modport source (output valid, stage_nf, stage_gain, last_stage, input ready);
	modport sink   (input valid, stage_nf, stage_gain, last_stage, output ready);
endinterface

interface fcnf_result_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] cascade_nf;
	logic signed [23:0] gain_sum;
	logic               saturated;

	modport source (output valid, cascade_nf, gain_sum, saturated, input ready);
	modport sink   (input valid, cascade_nf, gain_sum, saturated, output ready);
endinterface

FILE: hdl/fcnf_mul.sv
// Shared signed multiplier with a registered product.
module fcnf_mul
	import fcnf_pkg::*;
(
	input  logic                      clk,
	input  logic signed [MUL_A_W-1:0] a,
	input  logic signed [MUL_B_W-1:0] b,
	output logic signed [MUL_P_W-1:0] p
);

	// Register the product every cycle
	always_ff @(posedge clk) begin
		p <= a * b;
	end

endmodule

FILE: hdl/friis_cascade_noise_figure.sv
// Top level: Friis cascaded noise figure over a stream of receiver stages.
//
// Each stage item is worked through one shared 32x32 multiplier under a small
// sequencer, and the block is not ready while an item is in progress or a
// result waits. One power-of-ten evaluation runs the exponent split, ln2
// scaling and a 13-term series whose first term is taken directly, the rest
// with a reciprocal-multiply divide. The first stage of a cascade needs one
// evaluation, each later stage a second one for the "minus one" term; the next
// item is taken once the block is back in idle. A last stage with a nonzero
// sum adds the log10: a leading-one search of one bit per cycle, repeated
// squaring for the fraction bits, then the dB scaling and rounding, after which
// the result is held until taken and the accumulators then return to their
// cleared state. The multiplier gives one product per cycle.
module friis_cascade_noise_figure
	import fcnf_pkg::*;
#(
	parameter int DB_FRAC_BITS = 8,
	parameter int FACTOR_WIDTH = 48
) (
	input  logic          clk,
	input  logic          arst_n,
	fcnf_stage_if.sink    stage,
	fcnf_result_if.source result
);

	localparam int FF  = FACTOR_WIDTH / 2;
	localparam int Q   = DB_FRAC_BITS + 30;
	localparam int PW  = $clog2(FACTOR_WIDTH);
	localparam int SHW = FACTOR_WIDTH + 32;
	localparam logic [FACTOR_WIDTH-1:0] FMAX = {FACTOR_WIDTH{1'b1}};
	localparam logic signed [MUL_P_W-1:0] NF_HALF = MUL_P_W'(1) <<< (49 - DB_FRAC_BITS);
	localparam logic signed [MUL_P_W-1:0] NF_MAXW = MUL_P_W'(32767);
	localparam logic signed [MUL_P_W-1:0] NF_MINW = -MUL_P_W'(32768);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_PY   = 4'd1;
	localparam logic [3:0] ST_PT   = 4'd2;
	localparam logic [3:0] ST_PS0  = 4'd3;
	localparam logic [3:0] ST_SA   = 4'd4;
	localparam logic [3:0] ST_SB   = 4'd5;
	localparam logic [3:0] ST_SH   = 4'd6;
	localparam logic [3:0] ST_FIN  = 4'd7;
	localparam logic [3:0] ST_NRM  = 4'd8;
	localparam logic [3:0] ST_SQ   = 4'd9;
	localparam logic [3:0] ST_LG   = 4'd10;
	localparam logic [3:0] ST_RD   = 4'd11;
	localparam logic [3:0] ST_OUT  = 4'd12;
	localparam logic [3:0] ST_LH   = 4'd13;

	logic [3:0]               st_q;
	logic [FACTOR_WIDTH-1:0]  sum_q;
	logic signed [GAIN_W-1:0] gsum_q;
	logic                     first_q;
	logic                     ovf_q;
	logic                     sub_q;
	logic signed [X_W-1:0]    x_q;
	logic signed [NF_W-1:0]   g_q;
	logic                     last_q;
	logic signed [23:0]       e_q;
	logic [29:0]              t_q;
	logic [31:0]              m_q;
	logic [3:0]               n_q;
	logic [PW-1:0]            p_q;
	logic [4:0]               i_q;
	logic [29:0]              frac_q;
	logic signed [MUL_P_W-1:0] lo_q;
	logic signed [NF_W-1:0]   onf_q;
	logic                     osat_q;

	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] prod;

	logic [29:0]              t_nx;
	logic [29:0]              adiv;
	logic [30:0]              term_nx;
	logic [30:0]              top31;
	logic [31:0]              mm;
	logic [30:0]              mnx;
	logic signed [7:0]        pd;
	logic signed [24:0]       s_w;
	logic signed [24:0]       ns_w;
	logic [SHW-1:0]           shl;
	logic [FACTOR_WIDTH-1:0]  pwr;
	logic                     pwr_ovf;
	logic [FACTOR_WIDTH:0]    add_w;
	logic signed [X_W-1:0]    gs_w;
	logic signed [MUL_P_W-1:0] rr;

	fcnf_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	// Slice the registered product for each step
	assign t_nx    = prod[59:30];
	assign adiv    = prod[59:30];
	assign term_nx = prod[RECIP_SHIFT+30:RECIP_SHIFT];
	assign top31   = sum_q[FACTOR_WIDTH-1 -: 31];
	assign mm      = prod[61:30];
	assign mnx     = mm[31] ? mm[31:1] : mm[30:0];
	assign pd      = $signed(8'(p_q)) - $signed(8'(FF));
	assign rr      = ((prod <<< 30) + lo_q + NF_HALF) >>> (50 - DB_FRAC_BITS);

	// Select multiplier operands by step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (st_q)
			ST_PY: begin
				mul_a = {{(MUL_A_W-X_W){x_q[X_W-1]}}, x_q};
				mul_b = {3'd0, K_LOG2_10_DIV10};
			end
			ST_PT: begin
				mul_a = {2'd0, prod[Q-1:DB_FRAC_BITS]};
				mul_b = {2'd0, K_LN2};
			end
			ST_PS0: begin
				mul_a = {2'd0, t_nx};
				mul_b = {2'd0, t_nx};
			end
			ST_SA: begin
				mul_a = {2'd0, adiv};
				mul_b = {1'b0, recip_of(n_q)};
			end
			ST_SB: begin
				mul_a = {1'b0, term_nx};
				mul_b = {2'd0, t_q};
			end
			ST_NRM: begin
				mul_a = {1'b0, top31};
				mul_b = {1'b0, top31};
			end
			ST_SQ: begin
				mul_a = {1'b0, mnx};
				mul_b = {1'b0, mnx};
			end
			ST_LG: begin
				mul_a = {2'd0, frac_q};
				mul_b = {10'd0, K_DB_PER_LOG2};
			end
			ST_LH: begin
				mul_a = {{(MUL_A_W-8){pd[7]}}, pd};
				mul_b = {10'd0, K_DB_PER_LOG2};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Scale the series mantissa by the binary exponent, saturating on overflow
	always_comb begin
		s_w     = $signed({e_q[23], e_q}) + $signed(25'(FF - 30));
		ns_w    = -s_w;
		shl     = SHW'(m_q) << s_w[PW-1:0];
		pwr     = '0;
		pwr_ovf = 1'b0;
		if (!s_w[24]) begin
			if (s_w >= $signed(25'(FACTOR_WIDTH)) || (|shl[SHW-1:FACTOR_WIDTH])) begin
				pwr     = FMAX;
				pwr_ovf = 1'b1;
			end else begin
				pwr = shl[FACTOR_WIDTH-1:0];
			end
		end else if (ns_w <= 25'sd31) begin
			pwr = FACTOR_WIDTH'(m_q >> ns_w[4:0]);
		end
		add_w = {1'b0, sum_q} + {1'b0, pwr};
		gs_w  = $signed({gsum_q[GAIN_W-1], gsum_q}) +
			$signed({{(X_W-NF_W){g_q[NF_W-1]}}, g_q});
	end

	// Sequence one stage item through the shared multiplier
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			sum_q   <= '0;
			gsum_q  <= '0;
			first_q <= 1'b1;
			ovf_q   <= 1'b0;
			sub_q   <= 1'b0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (stage.valid) begin
						st_q  <= ST_PY;
						sub_q <= 1'b0;
					end
				end
				ST_PY:  st_q <= ST_PT;
				ST_PT:  st_q <= ST_PS0;
				ST_PS0: st_q <= ST_SA;
				ST_SA:  st_q <= ST_SB;
				ST_SB:  st_q <= (n_q == SERIES_TERMS) ? ST_SH : ST_SA;
				ST_SH: begin
					if (!sub_q) begin
						// Add the stage term, saturating at the top
						ovf_q <= ovf_q | pwr_ovf | add_w[FACTOR_WIDTH];
						if (add_w[FACTOR_WIDTH]) begin
							sum_q <= FMAX;
						end else begin
							sum_q <= add_w[FACTOR_WIDTH-1:0];
						end
						if (!first_q) begin
							sub_q <= 1'b1;
							st_q  <= ST_PY;
						end else begin
							st_q <= ST_FIN;
						end
					end else begin
						// Remove the "minus one" term, flooring at zero
						ovf_q <= ovf_q | pwr_ovf | (pwr > sum_q);
						if (pwr > sum_q) begin
							sum_q <= '0;
						end else begin
							sum_q <= sum_q - pwr;
						end
						st_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					first_q <= 1'b0;
					if (gs_w[X_W-1] != gs_w[X_W-2]) begin
						gsum_q <= gs_w[X_W-1] ? {1'b1, {(GAIN_W-1){1'b0}}}
							: {1'b0, {(GAIN_W-1){1'b1}}};
						ovf_q  <= 1'b1;
					end else begin
						gsum_q <= gs_w[GAIN_W-1:0];
					end
					st_q <= last_q ? ST_NRM : ST_IDLE;
				end
				ST_NRM: begin
					if (sum_q == '0) begin
						st_q <= ST_OUT;
					end else if (!sum_q[FACTOR_WIDTH-1]) begin
						sum_q <= sum_q << 1;
					end else begin
						st_q <= ST_SQ;
					end
				end
				ST_SQ:  st_q <= (i_q == SQUARE_LAST) ? ST_LG : ST_SQ;
				ST_LG:  st_q <= ST_LH;
				ST_LH:  st_q <= ST_RD;
				ST_RD:  st_q <= ST_OUT;
				ST_OUT: begin
					if (result.ready) begin
						sum_q   <= '0;
						gsum_q  <= '0;
						first_q <= 1'b1;
						ovf_q   <= 1'b0;
						st_q    <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Hold item fields, series terms, log digits and the result
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && stage.valid) begin
			x_q    <= $signed({{(X_W-NF_W){stage.stage_nf[NF_W-1]}},
				stage.stage_nf}) - $signed({gsum_q[GAIN_W-1], gsum_q});
			g_q    <= stage.stage_gain;
			last_q <= stage.last_stage;
		end
		if (st_q == ST_SH) begin
			x_q <= -$signed({gsum_q[GAIN_W-1], gsum_q});
		end
		if (st_q == ST_PT) begin
			e_q <= 24'(prod >>> Q);
		end
		// First series term equals t; continue the series from its second term
		if (st_q == ST_PS0) begin
			t_q <= t_nx;
			m_q <= {1'b0, Q30_ONE} + {2'd0, t_nx};
			n_q <= 4'd2;
		end
		if (st_q == ST_SB) begin
			m_q <= m_q + {1'b0, term_nx};
			n_q <= n_q + 4'd1;
		end
		if (st_q == ST_FIN) begin
			p_q <= PW'(FACTOR_WIDTH - 1);
		end
		if (st_q == ST_NRM) begin
			i_q    <= '0;
			frac_q <= '0;
			if (sum_q == '0) begin
				onf_q  <= {1'b1, {(NF_W-1){1'b0}}};
				osat_q <= 1'b1;
			end else if (!sum_q[FACTOR_WIDTH-1]) begin
				p_q <= p_q - PW'(1);
			end
		end
		if (st_q == ST_SQ) begin
			frac_q <= {frac_q[28:0], mm[31]};
			i_q    <= i_q + 5'd1;
		end
		// Hold the fraction part of the dB product
		if (st_q == ST_LH) begin
			lo_q <= prod;
		end
		if (st_q == ST_RD) begin
			if (rr > NF_MAXW) begin
				onf_q  <= 16'sd32767;
				osat_q <= 1'b1;
			end else if (rr < NF_MINW) begin
				onf_q  <= {1'b1, {(NF_W-1){1'b0}}};
				osat_q <= 1'b1;
			end else begin
				onf_q  <= rr[NF_W-1:0];
				osat_q <= ovf_q;
			end
		end
	end

	// Drive the channels
	assign stage.ready       = (st_q == ST_IDLE);
	assign result.valid      = (st_q == ST_OUT);
	assign result.cascade_nf = onf_q;
	assign result.gain_sum   = gsum_q;
	assign result.saturated  = osat_q;

endmodule

FILE: hdl/fcnf_checker.sv
// Port-level checks for the cascade noise figure block, bound to the top level.
module fcnf_props (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_saturated
);

	// A waiting result item holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_saturated))
		else $error("result item dropped or changed while stalled");

	// Never take a stage item while a result waits
	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("ready while a result item waits");

	// An accepted item keeps the block busy and shows no result at once
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready && !out_valid)
		else $error("block free right after accepting an item");

endmodule

bind friis_cascade_noise_figure fcnf_props u_fcnf_props (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (stage.valid),
	.in_ready      (stage.ready),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.out_saturated (result.saturated)
);

FILE: tb/fcnf_checker.sv
// Checker: predicts cascade results from accepted stage items and compares them.
module fcnf_tb_checker
	import fcnf_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	fcnf_stage_if  stage_mon,
	fcnf_result_if result_mon,
	output int     fail_count,
	output int     pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DBF = 8;
	localparam int FW  = 48;
	localparam int FFB = FW / 2;
	localparam longint unsigned FMAX = (64'd1 << FW) - 64'd1;
	localparam longint GMAX = 64'sd8388607;
	localparam longint GMIN = -64'sd8388608;

	typedef struct {
		logic signed [15:0] cascade_nf;
		logic signed [23:0] gain_sum;
		logic               saturated;
	} cascade_t;

	// predicted cascade state
	longint unsigned factor_sum;
	longint          gain_db;
	logic            first_pending;
	logic            sat_seen;

	cascade_t cascade_q[$];

	assign pending = cascade_q.size();

	// Linear factor of a dB value; raises sat_seen on saturation
	function automatic longint unsigned db_to_factor(input longint x);
		longint          y;
		longint          e;
		longint          s;
		longint unsigned frac;
		longint unsigned t;
		longint unsigned term;
		longint unsigned m;
		y = x * 64'sd356689313;
		e = y >>> (DBF + 30);
		frac = (longint'(y) & ((64'd1 << (DBF + 30)) - 64'd1)) >> DBF;
		t = (frac * 64'd744261118) >> 30;
		term = 64'd1073741824;
		m = 64'd1073741824;
		for (int n = 1; n <= 13; n++) begin
			term = ((term * t) >> 30) / n;
			m += term;
		end
		s = e + FFB - 30;
		if (s >= 0) begin
			if (s >= 64 || m > (FMAX >> s)) begin
				sat_seen = 1'b1;
				return FMAX;
			end
			return m << s;
		end
		if (s <= -64)
			return 64'd0;
		return m >> (-s);
	endfunction

	// 10*log10 of a nonzero linear factor, in units of 1/256 dB
	function automatic longint factor_to_db(input longint unsigned v);
		int              p;
		longint unsigned m;
		longint unsigned frac;
		longint          l;
		p = 63;
		frac = 0;
		while (p > 0 && !v[p])
			p--;
		m = (p >= 30) ? (v >> (p - 30)) : (v << (30 - p));
		for (int i = 1; i <= 30; i++) begin
			m = (m * m) >> 30;
			if (m >= 64'd2147483648) begin
				m >>= 1;
				frac |= 64'd1 << (30 - i);
			end
		end
		l = longint'(p - FFB) * 64'sd1073741824 + longint'(frac);
		return (l * 64'sd3156528 + (64'sd1 << (49 - DBF))) >>> (50 - DBF);
	endfunction

	// Advance the cascade by one stage; push a result on the last stage
	task automatic accumulate_stage(input longint nf, input longint g, input logic last);
		longint unsigned add;
		longint unsigned sub;
		longint          nf_out;
		cascade_t        r;
		add = db_to_factor(nf - gain_db);
		if (add > FMAX - factor_sum) begin
			factor_sum = FMAX;
			sat_seen = 1'b1;
		end else
			factor_sum += add;
		if (!first_pending) begin
			sub = db_to_factor(-gain_db);
			if (sub > factor_sum) begin
				factor_sum = 0;
				sat_seen = 1'b1;
			end else
				factor_sum -= sub;
		end
		first_pending = 1'b0;
		gain_db += g;
		if (gain_db > GMAX) begin
			gain_db = GMAX;
			sat_seen = 1'b1;
		end else if (gain_db < GMIN) begin
			gain_db = GMIN;
			sat_seen = 1'b1;
		end
		if (!last)
			return;
		if (factor_sum == 0) begin
			nf_out = -32768;
			sat_seen = 1'b1;
		end else begin
			nf_out = factor_to_db(factor_sum);
			if (nf_out > 32767) begin
				nf_out = 32767;
				sat_seen = 1'b1;
			end else if (nf_out < -32768) begin
				nf_out = -32768;
				sat_seen = 1'b1;
			end
		end
		r.cascade_nf = nf_out[15:0];
		r.gain_sum = gain_db[23:0];
		r.saturated = sat_seen;
		cascade_q.push_back(r);
		factor_sum = 0;
		gain_db = 0;
		first_pending = 1'b1;
		sat_seen = 1'b0;
	endtask

	task automatic report(input string what, input longint got, input longint want);
		$display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		factor_sum = 0;
		gain_db = 0;
		first_pending = 1'b1;
		sat_seen = 1'b0;
	end

	// Watch both channels at each rising edge
	always @(posedge clk) begin
		cascade_t exp_r;
		if (arst_n) begin
			if (stage_mon.valid && stage_mon.ready)
				accumulate_stage(longint'(stage_mon.stage_nf),
					longint'(stage_mon.stage_gain), stage_mon.last_stage);
			if (result_mon.valid && result_mon.ready) begin
				if (cascade_q.size() == 0)
					report("unexpected result", result_mon.cascade_nf, 0);
				else begin
					exp_r = cascade_q.pop_front();
					if (result_mon.cascade_nf !== exp_r.cascade_nf)
						report("cascade_nf", result_mon.cascade_nf, exp_r.cascade_nf);
					if (result_mon.gain_sum !== exp_r.gain_sum)
						report("gain_sum", result_mon.gain_sum, exp_r.gain_sum);
					if (result_mon.saturated !== exp_r.saturated)
						report("saturated", result_mon.saturated, exp_r.saturated);
				end
			end
		end
	end
endmodule

FILE: tb/friis_cascade_noise_figure_tb.sv
// Testbench top: clock, reset, stage stimulus, result stalls and verdict.
module friis_cascade_noise_figure_tb;
	import fcnf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_TARGET = 1550;
	localparam longint CYCLE_LIMIT = 3000000;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   items_sent;
	int   burst_left;
	longint cycles;
	bit   gain_runs_done;

	fcnf_stage_if  stage_ch();
	fcnf_result_if result_ch();

	friis_cascade_noise_figure dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stage  (stage_ch),
		.result (result_ch)
	);

	fcnf_tb_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.stage_mon  (stage_ch),
		.result_mon (result_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Offer one stage item, with a random gap between bursts
	task automatic send_stage(input logic [15:0] nf, input logic [15:0] g, input logic last);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				stage_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		stage_ch.valid <= 1'b1;
		stage_ch.stage_nf <= nf;
		stage_ch.stage_gain <= g;
		stage_ch.last_stage <= last;
		do @(posedge clk); while (!stage_ch.ready);
		items_sent++;
	endtask

	// Cascade of realistic stages, or fully random stages when wild
	task automatic send_cascade(input int stages, input bit wild);
		logic [15:0] nf;
		logic [15:0] g;
		for (int i = 0; i < stages; i++) begin
			if (wild) begin
				nf = 16'($urandom);
				g = 16'($urandom);
			end else begin
				nf = 16'($urandom_range(0, 6400) - 512);
				g = 16'($urandom_range(0, 12800) - 5120);
			end
			send_stage(nf, g, i == stages - 1);
		end
	endtask

	// Result side: stall patterns, plus one long hold-off
	initial begin
		int rx_cycles;
		int mode;
		result_ch.ready = 1'b0;
		rx_cycles = 0;
		mode = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			rx_cycles++;
			if (rx_cycles % 256 == 0)
				mode = $urandom_range(0, 3);
			if (rx_cycles == 20000) begin
				result_ch.ready <= 1'b0;
				repeat (3000) @(negedge clk);
			end
			case (mode)
				0: result_ch.ready <= 1'b1;
				1: result_ch.ready <= 1'($urandom_range(0, 1));
				2: result_ch.ready <= ($urandom_range(0, 4) == 0);
				default: result_ch.ready <= ((rx_cycles % 37) < 20);
			endcase
		end
	end

	// Run limit
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		int pick;
		stage_ch.valid = 1'b0;
		stage_ch.stage_nf = '0;
		stage_ch.stage_gain = '0;
		stage_ch.last_stage = 1'b0;
		items_sent = 0;
		burst_left = 0;
		gain_runs_done = 1'b0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: extremes, typical chain, underflow, floor, lossy stages
		send_stage(16'sd0, 16'sd0, 1'b1);
		send_stage(16'sd32767, 16'sd0, 1'b1);
		send_stage(-16'sd32768, 16'sd0, 1'b1);
		send_stage(16'sd512, 16'sd5120, 1'b0);
		send_stage(16'sd1280, 16'sd2560, 1'b0);
		send_stage(16'sd2560, 16'sd0, 1'b1);
		send_stage(-16'sd2560, 16'sd0, 1'b0);
		send_stage(-16'sd2560, 16'sd0, 1'b1);
		send_stage(16'sd512, -16'sd32768, 1'b0);
		send_stage(16'sd32767, -16'sd32768, 1'b0);
		send_stage(16'sd0, 16'sd32767, 1'b1);
		send_stage(16'sd100, 16'sd32767, 1'b1);
		send_stage(16'sd100, -16'sd32768, 1'b1);
		send_stage(-16'sd32768, 16'sd32767, 1'b0);
		send_stage(16'sd32767, -16'sd32768, 1'b1);

		// Random: mostly realistic cascades, some wild, two gain overflow runs
		while (items_sent < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 85)
				send_cascade($urandom_range(1, 6), 1'b0);
			else if (pick < 98 || gain_runs_done || items_sent > ITEM_TARGET - 600)
				send_cascade($urandom_range(1, 4), 1'b1);
			else begin
				for (int i = 0; i < 260; i++)
					send_stage(16'($urandom_range(0, 2560)), 16'sd32767, i == 259);
				for (int i = 0; i < 260; i++)
					send_stage(16'($urandom_range(0, 2560)), -16'sd32768, i == 259);
				gain_runs_done = 1'b1;
			end
		end
		@(negedge clk);
		stage_ch.valid <= 1'b0;

		// Drain
		while (pending != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
